### src/psq_pkg.sv
// Shared types, codes and elaboration helpers for the positional sequence store.
// No dependencies; every other file in src takes its names from here.
`default_nettype none

package psq_pkg;

  // Field widths fixed by the transaction format
  localparam int KIND_W   = 3;
  localparam int POS_W    = 11;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  // Default number of entries
  localparam int PSQ_CAPACITY = 1024;

  // Fan-in of each level of the read-out reduction tree
  localparam int TREE_FANIN = 32;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Cell operations broadcast along the chain
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } psq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;
  } psq_rsp_t;

  // Command seen by every cell of the chain
  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] value;
  } psq_cmd_t;

  // Number of nodes at level k of a tree over n leaves
  function automatic int tree_width(int n, int k);
    int w;
    w = n;
    for (int i = 0; i < k; i++) begin
      w = (w + TREE_FANIN - 1) / TREE_FANIN;
    end
    return w;
  endfunction

  // Levels needed to reduce n leaves to a single node
  function automatic int tree_levels(int n);
    int w;
    int l;
    w = n;
    l = 0;
    while (w > 1) begin
      w = (w + TREE_FANIN - 1) / TREE_FANIN;
      l++;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

### src/psq_cell.sv
// One storage cell of the shift chain: holds a single entry and trades it with its neighbours.
// Depends on psq_pkg for the command struct and operation codes.
`default_nettype none

module psq_cell #(
  parameter int IW    = 10,
  parameter int INDEX = 0
) (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire psq_pkg::psq_cmd_t  cmd,
  input  wire logic [IW-1:0]      slot,
  input  wire logic [psq_pkg::DATA_W-1:0] left,
  input  wire logic [psq_pkg::DATA_W-1:0] right,
  output logic [psq_pkg::DATA_W-1:0]      data,
  output logic [psq_pkg::DATA_W-1:0]      tap
);

  localparam logic [IW-1:0] MY_SLOT = IW'(INDEX);

  // Shift right above an insert, shift left from an erase, capture the erased entry
  always_ff @(posedge clk) begin
    if (load) begin
      case (cmd.op)
        psq_pkg::OP_INSERT: begin
          if (MY_SLOT > slot) begin
            data <= left;
          end else if (MY_SLOT == slot) begin
            data <= cmd.value;
          end
        end
        psq_pkg::OP_ERASE: begin
          if (MY_SLOT >= slot) begin
            data <= right;
          end
        end
        default: begin
        end
      endcase
      tap <= (cmd.op == psq_pkg::OP_ERASE && MY_SLOT == slot) ? data : '0;
    end
  end

endmodule

`default_nettype wire

### src/psq_or_tree.sv
// Registered OR-reduction tree that gathers the one non-zero cell tap into a single word.
// Depends on psq_pkg for the fan-in and the level helpers.
`default_nettype none

module psq_or_tree #(
  parameter int N      = 1024,
  parameter int LEVELS = 2
) (
  input  wire logic                       clk,
  input  wire logic [psq_pkg::DATA_W-1:0] leaf [N],
  output logic [psq_pkg::DATA_W-1:0]      root
);

  // src[k] feeds level k+1; node[k] is the registered output of level k+1
  logic [psq_pkg::DATA_W-1:0] src       [LEVELS][N];
  logic [psq_pkg::DATA_W-1:0] node      [LEVELS][N];
  logic [psq_pkg::DATA_W-1:0] node_next [LEVELS][N];

  // Feed the first level from the leaves and each later level from the one below
  always_comb begin
    for (int j = 0; j < N; j++) begin
      src[0][j] = leaf[j];
    end
    for (int k = 1; k < LEVELS; k++) begin
      for (int j = 0; j < N; j++) begin
        src[k][j] = node[k-1][j];
      end
    end
  end

  // Combine groups of the level below; nodes past the level's width stay zero
  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < N; j++) begin
        node_next[k][j] = '0;
        if (j < psq_pkg::tree_width(N, k + 1)) begin
          for (int m = 0; m < psq_pkg::TREE_FANIN; m++) begin
            if (j * psq_pkg::TREE_FANIN + m < psq_pkg::tree_width(N, k)) begin
              node_next[k][j] = node_next[k][j] | src[k][j * psq_pkg::TREE_FANIN + m];
            end
          end
        end
      end
    end
  end

  // Register every level
  always_ff @(posedge clk) begin
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < N; j++) begin
        node[k][j] <= node_next[k][j];
      end
    end
  end

  assign root = node[LEVELS-1][0];

endmodule

`default_nettype wire

### src/positional_sequence_store.sv
// Top level of the positional sequence store: request decode, cell chain, read-out tree.
// Depends on psq_pkg, psq_cell and psq_or_tree.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------
//   req     | in        | req_valid/req_stall  | psq_pkg::psq_req_t
//   rsp     | out       | rsp_valid/rsp_stall  | psq_pkg::psq_rsp_t
//
// Each transaction passes through the cell chain, which shifts and captures the
// removed entry, then the LEVELS registered levels of the OR tree, then the response
// register; the next request is accepted once the response register is loaded, which
// waits while a stalled response is held. The tree depth is ceil(log32(CAPACITY)).
// Reset clears the entry count and the handshake state; cell contents are undefined.
// A stalled response holds in its register while the next request is accepted.
`default_nettype none

module positional_sequence_store #(
  parameter int CAPACITY = psq_pkg::PSQ_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire psq_pkg::psq_req_t  req_data,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output psq_pkg::psq_rsp_t       rsp_data
);

  localparam int IW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int PW     = CW + psq_pkg::POS_W;
  localparam int LEVELS = psq_pkg::tree_levels(CAPACITY);
  localparam int WW     = $clog2(LEVELS + 1);

  // Control state
  logic          busy;
  logic [WW-1:0] wait_cnt;
  logic [CW-1:0] count;

  // Payload held for the transaction in flight
  logic [CW-1:0]                res_count;
  logic [psq_pkg::STATUS_W-1:0] res_status;

  // Decode
  logic                         accept;
  logic                         is_add;
  logic                         is_rem;
  logic                         full;
  logic                         empty;
  logic [PW-1:0]                pos_ext;
  logic [PW-1:0]                cnt_ext;
  logic [PW-1:0]                last_ext;
  logic [PW-1:0]                slot_ext;
  logic [IW-1:0]                slot;
  psq_pkg::psq_cmd_t            cmd;
  logic [CW-1:0]                count_next;
  logic [psq_pkg::STATUS_W-1:0] status_next;

  // Chain and read-out
  logic [psq_pkg::DATA_W-1:0] chain [CAPACITY];
  logic [psq_pkg::DATA_W-1:0] taps  [CAPACITY];
  logic [psq_pkg::DATA_W-1:0] removed;
  logic                       tree_done;
  logic                       rsp_load;
  logic [CW+psq_pkg::COUNT_W-1:0] res_count_ext;

  assign req_stall = busy || rst;
  assign accept    = req_valid && !req_stall;

  // Classify the request against the current fill
  always_comb begin
    is_add = req_data.kind inside {psq_pkg::KIND_PUSH_FRONT, psq_pkg::KIND_PUSH_BACK,
                                   psq_pkg::KIND_INSERT};
    is_rem = req_data.kind inside {psq_pkg::KIND_POP_FRONT, psq_pkg::KIND_POP_BACK,
                                   psq_pkg::KIND_ERASE};
    full   = (count == CW'(CAPACITY));
    empty  = (count == '0);
  end

  // Clamp the position to the front or back of the sequence
  always_comb begin
    pos_ext  = {{CW{1'b0}}, req_data.position};
    cnt_ext  = {{psq_pkg::POS_W{1'b0}}, count};
    last_ext = cnt_ext - PW'(1);
    slot_ext = '0;
    case (req_data.kind)
      psq_pkg::KIND_PUSH_BACK: slot_ext = cnt_ext;
      psq_pkg::KIND_POP_BACK:  slot_ext = last_ext;
      psq_pkg::KIND_INSERT: begin
        if (pos_ext == '0 || empty) begin
          slot_ext = '0;
        end else if (pos_ext >= cnt_ext) begin
          slot_ext = cnt_ext;
        end else begin
          slot_ext = pos_ext;
        end
      end
      psq_pkg::KIND_ERASE: begin
        if (pos_ext == '0) begin
          slot_ext = '0;
        end else if (pos_ext >= last_ext) begin
          slot_ext = last_ext;
        end else begin
          slot_ext = pos_ext;
        end
      end
      default: slot_ext = '0;
    endcase
    slot = slot_ext[IW-1:0];
  end

  // Pick the chain operation, the new count and the status
  always_comb begin
    cmd.value   = req_data.value;
    cmd.op      = psq_pkg::OP_HOLD;
    count_next  = count;
    status_next = psq_pkg::ST_DONE;
    if (is_add) begin
      if (full) begin
        status_next = psq_pkg::ST_FULL;
      end else begin
        cmd.op     = psq_pkg::OP_INSERT;
        count_next = count + CW'(1);
      end
    end else if (is_rem) begin
      if (empty) begin
        status_next = psq_pkg::ST_EMPTY;
      end else begin
        cmd.op     = psq_pkg::OP_ERASE;
        count_next = count - CW'(1);
      end
    end
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [psq_pkg::DATA_W-1:0] left;
    logic [psq_pkg::DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = chain[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = chain[i+1];
    end

    psq_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .load  (accept),
      .cmd   (cmd),
      .slot  (slot),
      .left  (left),
      .right (right),
      .data  (chain[i]),
      .tap   (taps[i])
    );
  end

  // Gather the removed entry
  psq_or_tree #(
    .N      (CAPACITY),
    .LEVELS (LEVELS)
  ) u_tree (
    .clk  (clk),
    .leaf (taps),
    .root (removed)
  );

  assign tree_done = busy && (wait_cnt == WW'(LEVELS));
  assign rsp_load  = tree_done && (!rsp_valid || !rsp_stall);

  // Count, busy flag and tree delay
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      busy     <= 1'b0;
      wait_cnt <= '0;
    end else if (accept) begin
      count    <= count_next;
      busy     <= 1'b1;
      wait_cnt <= '0;
    end else if (rsp_load) begin
      busy     <= 1'b0;
    end else if (busy && !tree_done) begin
      wait_cnt <= wait_cnt + WW'(1);
    end
  end

  // Hold count and status for the transaction in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      res_count  <= count_next;
      res_status <= status_next;
    end
  end

  assign res_count_ext = {{psq_pkg::COUNT_W{1'b0}}, res_count};

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data.removed_value <= $signed(removed);
      rsp_data.count         <= res_count_ext[psq_pkg::COUNT_W-1:0];
      rsp_data.status        <= res_status;
    end
  end

endmodule

`default_nettype wire

### src/psq_checker.sv
// Port-level checks for the positional sequence store, bound to its top level.
// Depends on psq_pkg and on the ports of positional_sequence_store.
`default_nettype none

module psq_checker #(
  parameter int CAPACITY = psq_pkg::PSQ_CAPACITY
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_stall,
  input wire psq_pkg::psq_req_t req_data,
  input wire logic              rsp_valid,
  input wire logic              rsp_stall,
  input wire psq_pkg::psq_rsp_t rsp_data
);

  // Hold a stalled response transaction
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // Admit one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while one is in flight");

  // A dropped push reports a full store
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == psq_pkg::ST_FULL |->
      rsp_data.count == psq_pkg::COUNT_W'(CAPACITY) && rsp_data.removed_value == '0)
    else $error("full status with wrong count or value");

  // A removal from an empty store reports nothing removed
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == psq_pkg::ST_EMPTY |->
      rsp_data.count == '0 && rsp_data.removed_value == '0)
    else $error("empty status with wrong count or value");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.status == psq_pkg::ST_DONE ||
                  rsp_data.status == psq_pkg::ST_EMPTY ||
                  rsp_data.status == psq_pkg::ST_FULL)
    else $error("undefined status code");

endmodule

bind positional_sequence_store psq_checker #(.CAPACITY(CAPACITY)) u_psq_checker (.*);

`default_nettype wire
